// File: hw/rtl/tftp_read_receiver_core_defines.svh
// assertion macros for the tftp read receiver
`ifndef TFTP_READ_RECEIVER_CORE_DEFINES_SVH
`define TFTP_READ_RECEIVER_CORE_DEFINES_SVH

// checked at every edge, reset included
`define TRR_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("tftp read receiver check failed");

// checked outside reset
`define TRR_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tftp read receiver check failed");

`endif

// File: hw/rtl/trr_pkg.sv
// shared types and constants of the tftp read receiver
package trr_pkg;

   localparam int CMD_W  = 3;
   localparam int PORT_W = 16;
   localparam int BLK_W  = 16;
   localparam int LEN_W  = 16;
   localparam int KIND_W = 2;
   localparam int NUM_W  = 16;
   localparam int OUTC_W = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [CMD_W-1:0] CMD_DATA    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ERROR   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_OACK    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_TIMEOUT = 3'd3;

   localparam logic [KIND_W-1:0] SEND_NONE  = 2'd0;
   localparam logic [KIND_W-1:0] SEND_ACK   = 2'd1;
   localparam logic [KIND_W-1:0] SEND_ERROR = 2'd2;

   localparam logic [NUM_W-1:0] CODE_DISK_FULL = 16'd3;
   localparam logic [NUM_W-1:0] CODE_ILLEGAL   = 16'd4;
   localparam logic [NUM_W-1:0] CODE_TID       = 16'd5;

   localparam logic [OUTC_W-1:0] OUT_RUNNING = 2'd0;
   localparam logic [OUTC_W-1:0] OUT_SUCCESS = 2'd1;
   localparam logic [OUTC_W-1:0] OUT_REMOTE  = 2'd2;
   localparam logic [OUTC_W-1:0] OUT_LOCAL   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REPLY_TIMER = 2'd1;

   localparam logic [BLK_W-1:0] DEFAULT_BLOCK_SIZE = 16'd512;

   typedef enum logic [2:0] {
      EV_DATA    = 3'd0,
      EV_ERROR   = 3'd1,
      EV_OACK    = 3'd2,
      EV_TIMEOUT = 3'd3,
      EV_OTHER   = 3'd4
   } event_kind_type;

   typedef struct packed {
      event_kind_type    kind;
      logic [PORT_W-1:0] port;
      logic [BLK_W-1:0]  block;
      logic [LEN_W-1:0]  length;
      logic              write_failed;
   } event_type;

   typedef struct packed {
      logic      valid;
      event_type ev;
   } queue_out_type;

   typedef struct packed {
      logic [KIND_W-1:0] send_kind;
      logic [NUM_W-1:0]  send_number;
      logic [OUTC_W-1:0] outcome;
      logic              payload_accepted;
   } result_type;

endpackage

// File: hw/rtl/tftp_read_receiver_core.sv
// top level of the tftp read transfer receiver
//
//   channel  direction  handshake             carries
//   req_     in         req_push / req_full   command, port, block, length, write fail
//   rsp_     out        rsp_empty / rsp_pop   send kind, send number, outcome, accepted
//   csr_     in         csr_valid / csr_ready block size, reply timer enable
//
// one item per cycle sustained while the result side pops; an accepted item passes the
// front queue slot, then the back end result register, before it reaches the result ports
// the back end updates transfer state as each item fires, so items flow back to back
// reset clears the queue, the transfer state and the registers (block size 512)
// a stalled result side backs up the two-entry front queue, then raises req_full
module tftp_read_receiver_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [trr_pkg::CMD_W-1:0]      req_command,
   input  logic [trr_pkg::PORT_W-1:0]     req_source_port,
   input  logic [trr_pkg::BLK_W-1:0]      req_block_number,
   input  logic [trr_pkg::LEN_W-1:0]      req_payload_length,
   input  logic                           req_write_failed,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [trr_pkg::KIND_W-1:0]     rsp_send_kind,
   output logic [trr_pkg::NUM_W-1:0]      rsp_send_number,
   output logic [trr_pkg::OUTC_W-1:0]     rsp_outcome,
   output logic                           rsp_payload_accepted,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [trr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [trr_pkg::CSR_DATA_W-1:0] csr_data
);
   import trr_pkg::*;

   queue_out_type q_out;
   logic          q_pop;
   result_type    rsp;

   trr_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_command        (req_command),
      .req_source_port    (req_source_port),
      .req_block_number   (req_block_number),
      .req_payload_length (req_payload_length),
      .req_write_failed   (req_write_failed),
      .q_out              (q_out),
      .q_pop              (q_pop)
   );

   trr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_out     (q_out),
      .q_pop     (q_pop),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp       (rsp),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

   assign rsp_send_kind        = rsp.send_kind;
   assign rsp_send_number      = rsp.send_number;
   assign rsp_outcome          = rsp.outcome;
   assign rsp_payload_accepted = rsp.payload_accepted;

endmodule

// File: hw/rtl/trr_front.sv
// front end: takes events, classifies the command and queues them
module trr_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [trr_pkg::CMD_W-1:0]    req_command,
   input  logic [trr_pkg::PORT_W-1:0]   req_source_port,
   input  logic [trr_pkg::BLK_W-1:0]    req_block_number,
   input  logic [trr_pkg::LEN_W-1:0]    req_payload_length,
   input  logic                         req_write_failed,
   output trr_pkg::queue_out_type       q_out,
   input  logic                         q_pop
);
   import trr_pkg::*;

   event_type           slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   event_type           ev_in;
   event_kind_type      kind;
   logic                push_fire, pop_fire;

   always_comb begin
      case (req_command)
         CMD_DATA:    kind = EV_DATA;
         CMD_ERROR:   kind = EV_ERROR;
         CMD_OACK:    kind = EV_OACK;
         CMD_TIMEOUT: kind = EV_TIMEOUT;
         default:     kind = EV_OTHER;
      endcase
   end

   always_comb begin
      ev_in.kind         = kind;
      ev_in.port         = req_source_port;
      ev_in.block        = req_block_number;
      ev_in.length       = req_payload_length;
      ev_in.write_failed = req_write_failed;
   end

   assign req_full  = (count_ff == QCNT_W'(QDEPTH));
   assign push_fire = req_push && !req_full;
   assign pop_fire  = q_pop && (count_ff != '0);

   assign q_out.valid = (count_ff != '0);
   assign q_out.ev    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_fire ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_fire ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= ev_in;
      end
   end

endmodule

// File: hw/rtl/trr_back.sv
// back end: transfer state, configuration and the result register
module trr_back (
   input  logic                           clock,
   input  logic                           reset,
   input  trr_pkg::queue_out_type         q_out,
   output logic                           q_pop,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [trr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [trr_pkg::CSR_DATA_W-1:0] csr_data,
   output trr_pkg::result_type            rsp,
   output logic                           rsp_empty,
   input  logic                           rsp_pop
);
   import trr_pkg::*;

   logic [BLK_W-1:0]  block_size_ff;
   logic              reply_timer_ff;
   logic [BLK_W-1:0]  last_block_ff, last_block_in;
   logic [PORT_W-1:0] server_port_ff, server_port_in;
   logic              finishing_ff, finishing_in;
   logic              ended_ff, ended_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;
   event_type         ev;
   logic              fire;
   logic              port_ok;
   logic              blk_ok;
   logic [BLK_W:0]    blk_next;

   assign csr_ready = 1'b1;
   assign ev        = q_out.ev;
   assign fire      = q_out.valid && (!rsp_valid_ff || rsp_pop);
   assign q_pop     = fire;
   assign rsp       = rsp_ff;
   assign rsp_empty = !rsp_valid_ff;

   assign port_ok  = (server_port_ff == '0) || (server_port_ff == ev.port);
   assign blk_next = {1'b0, last_block_ff} + 1'b1;
   assign blk_ok   = ({1'b0, ev.block} == blk_next) || (ev.block == last_block_ff);

   always_comb begin
      rsp_in         = '0;
      last_block_in  = last_block_ff;
      server_port_in = server_port_ff;
      finishing_in   = finishing_ff;
      ended_in       = ended_ff;
      if (!ended_ff) begin
         if (ev.kind == EV_TIMEOUT) begin
            if (finishing_ff) begin
               ended_in       = 1'b1;
               rsp_in.outcome = OUT_SUCCESS;
            end else if (!reply_timer_ff) begin
               ended_in       = 1'b1;
               rsp_in.outcome = OUT_REMOTE;
            end else begin
               rsp_in.send_kind   = SEND_ACK;
               rsp_in.send_number = last_block_ff;
            end
         end else begin
            if (server_port_ff == '0) begin
               server_port_in = ev.port;
            end
            if (!port_ok) begin
               rsp_in.send_kind   = SEND_ERROR;
               rsp_in.send_number = CODE_TID;
            end else begin
               case (ev.kind)
                  EV_ERROR: begin
                     ended_in       = 1'b1;
                     rsp_in.outcome = OUT_REMOTE;
                  end
                  EV_DATA: begin
                     if (ev.write_failed) begin
                        ended_in           = 1'b1;
                        rsp_in.send_kind   = SEND_ERROR;
                        rsp_in.send_number = CODE_DISK_FULL;
                        rsp_in.outcome     = OUT_LOCAL;
                     end else if (!blk_ok) begin
                        ended_in           = 1'b1;
                        rsp_in.send_kind   = SEND_ERROR;
                        rsp_in.send_number = CODE_ILLEGAL;
                        rsp_in.outcome     = OUT_LOCAL;
                     end else begin
                        last_block_in = ev.block;
                        if (ev.length < block_size_ff) begin
                           finishing_in = 1'b1;
                        end
                        rsp_in.send_kind        = SEND_ACK;
                        rsp_in.send_number      = ev.block;
                        rsp_in.payload_accepted = 1'b1;
                     end
                  end
                  EV_OACK: begin
                     if (last_block_ff != '0) begin
                        ended_in           = 1'b1;
                        rsp_in.send_kind   = SEND_ERROR;
                        rsp_in.send_number = CODE_ILLEGAL;
                        rsp_in.outcome     = OUT_LOCAL;
                     end else begin
                        rsp_in.send_kind = SEND_ACK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff  <= DEFAULT_BLOCK_SIZE;
         reply_timer_ff <= 1'b0;
         last_block_ff  <= '0;
         server_port_ff <= '0;
         finishing_ff   <= 1'b0;
         ended_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            last_block_ff  <= last_block_in;
            server_port_ff <= server_port_in;
            finishing_ff   <= finishing_in;
            ended_ff       <= ended_in;
         end
         if (csr_valid) begin
            case (csr_index)
               REG_BLOCK_SIZE:  block_size_ff  <= csr_data;
               REG_REPLY_TIMER: reply_timer_ff <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: hw/rtl/trr_checker.sv
// port level checks of the tftp read receiver and their binding
`include "tftp_read_receiver_core_defines.svh"

module trr_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_full,
   input logic                       rsp_empty,
   input logic                       rsp_pop,
   input logic [trr_pkg::KIND_W-1:0] rsp_send_kind,
   input logic [trr_pkg::NUM_W-1:0]  rsp_send_number,
   input logic [trr_pkg::OUTC_W-1:0] rsp_outcome,
   input logic                       rsp_payload_accepted
);
   import trr_pkg::*;

   localparam int RSP_BITS_W = KIND_W + NUM_W + OUTC_W + 1;

   logic                  rsp_shown;
   logic                  ack_running;
   logic                  send_none;
   logic [RSP_BITS_W-1:0] rsp_bits;

   assign rsp_shown   = !rsp_empty;
   assign ack_running = (rsp_send_kind == SEND_ACK) && (rsp_outcome == OUT_RUNNING);
   assign send_none   = rsp_shown && (rsp_send_kind == SEND_NONE);
   assign rsp_bits    = {rsp_send_kind, rsp_send_number, rsp_outcome, rsp_payload_accepted};

   `TRR_ASSERT_ALWAYS(a_reset_drains, clock, reset |=> rsp_empty && !req_full)
   `TRR_ASSERT(a_accept_acks, clock, reset, rsp_shown && rsp_payload_accepted |-> ack_running)
   `TRR_ASSERT(a_none_zero, clock, reset, send_none |-> rsp_send_number == '0)
   `TRR_ASSERT(a_rsp_holds, clock, reset, rsp_shown && !rsp_pop |=> rsp_shown && $stable(rsp_bits))

endmodule

bind tftp_read_receiver_core trr_checker u_trr_checker (.*);

// File: bench/tftp_read_receiver_core_tb.sv
// self-checking testbench for the tftp read transfer receiver core
`timescale 1ns / 100ps

module tftp_read_receiver_core_tb;
   import trr_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;

   localparam logic [CMD_W-1:0] CMD_OTHER       = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_MID   = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [PORT_W-1:0] port;
      logic [BLK_W-1:0]  block;
      logic [LEN_W-1:0]  length;
      logic              write_failed;
   } packet_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [CMD_W-1:0]      req_command = '0;
   logic [PORT_W-1:0]     req_source_port = '0;
   logic [BLK_W-1:0]      req_block_number = '0;
   logic [LEN_W-1:0]      req_payload_length = '0;
   logic                  req_write_failed = 1'b0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [KIND_W-1:0]     rsp_send_kind;
   logic [NUM_W-1:0]      rsp_send_number;
   logic [OUTC_W-1:0]     rsp_outcome;
   logic                  rsp_payload_accepted;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   packet_item_type pending_events[$];
   result_type      expected_replies[$];

   // receiver copy of the configuration and transfer state
   logic [BLK_W-1:0]  cfg_block_size = DEFAULT_BLOCK_SIZE;
   logic              cfg_reply_timer = 1'b0;
   logic [BLK_W-1:0]  acked_block = '0;
   logic [PORT_W-1:0] latched_port = '0;
   logic              xfer_finishing = 1'b0;
   logic              xfer_ended = 1'b0;

   logic [PORT_W-1:0] server_port_sel;
   int                gen_block;
   int                tx_idle_pct = 10;
   int                rx_idle_pct = 61;
   bit                rx_hold = 1'b0;
   bit                req_taken = 1'b0;
   int                accepted_count = 0;
   int                reply_index = 0;
   int                reply_errors = 0;
   int                cycle_count = 0;

   tftp_read_receiver_core i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_command          (req_command),
      .req_source_port      (req_source_port),
      .req_block_number     (req_block_number),
      .req_payload_length   (req_payload_length),
      .req_write_failed     (req_write_failed),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_send_kind        (rsp_send_kind),
      .rsp_send_number      (rsp_send_number),
      .rsp_outcome          (rsp_outcome),
      .rsp_payload_accepted (rsp_payload_accepted),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always #5 clock = ~clock;

   function automatic result_type next_reply(packet_item_type ev);
      result_type r;
      r = '0;
      if (xfer_ended) return r;
      if (ev.command == CMD_TIMEOUT) begin
         if (xfer_finishing) begin
            xfer_ended = 1'b1;
            r.outcome = OUT_SUCCESS;
         end else if (!cfg_reply_timer) begin
            xfer_ended = 1'b1;
            r.outcome = OUT_REMOTE;
         end else begin
            r.send_kind = SEND_ACK;
            r.send_number = acked_block;
         end
         return r;
      end
      if (latched_port == '0) latched_port = ev.port;
      if (latched_port != ev.port) begin
         r.send_kind = SEND_ERROR;
         r.send_number = CODE_TID;
         return r;
      end
      case (ev.command)
         CMD_ERROR: begin
            xfer_ended = 1'b1;
            r.outcome = OUT_REMOTE;
         end
         CMD_DATA: begin
            if (ev.write_failed) begin
               xfer_ended = 1'b1;
               r.send_kind = SEND_ERROR;
               r.send_number = CODE_DISK_FULL;
               r.outcome = OUT_LOCAL;
            end else if ({1'b0, ev.block} != {1'b0, acked_block} + 17'd1 &&
                         ev.block != acked_block) begin
               xfer_ended = 1'b1;
               r.send_kind = SEND_ERROR;
               r.send_number = CODE_ILLEGAL;
               r.outcome = OUT_LOCAL;
            end else begin
               acked_block = ev.block;
               if (ev.length < cfg_block_size) xfer_finishing = 1'b1;
               r.send_kind = SEND_ACK;
               r.send_number = acked_block;
               r.payload_accepted = 1'b1;
            end
         end
         CMD_OACK: begin
            if (acked_block != '0) begin
               xfer_ended = 1'b1;
               r.send_kind = SEND_ERROR;
               r.send_number = CODE_ILLEGAL;
               r.outcome = OUT_LOCAL;
            end else begin
               r.send_kind = SEND_ACK;
               r.send_number = '0;
            end
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("reply %0d: %s got %0d, expected %0d", reply_index, what, got, want);
      reply_errors++;
   endtask

   task automatic add_event(logic [CMD_W-1:0] cmd, logic [PORT_W-1:0] port,
                            logic [BLK_W-1:0] blk, logic [LEN_W-1:0] len, logic wf);
      packet_item_type ev;
      ev = '{cmd, port, blk, len, wf};
      pending_events = {pending_events, ev};
   endtask

   function automatic logic [15:0] rnd_word();
      return 16'($urandom);
   endfunction

   function automatic logic rnd_bit();
      return 1'($urandom);
   endfunction

   function automatic logic [PORT_W-1:0] foreign_port();
      logic [PORT_W-1:0] p;
      p = PORT_W'($urandom);
      if (p == server_port_sel) p = p ^ 16'h1;
      return p;
   endfunction

   function automatic logic [LEN_W-1:0] full_length();
      return LEN_W'($urandom_range(int'(cfg_block_size), 65535));
   endfunction

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == REG_BLOCK_SIZE) cfg_block_size = value;
      else if (idx == REG_REPLY_TIMER) cfg_reply_timer = value[0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_events.size() != 0 || req_push || expected_replies.size() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   // well-formed transfer traffic mixed with foreign and ignored packets
   task automatic queue_random_phase(int count);
      int pick;
      logic [CMD_W-1:0] cmd;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            gen_block++;
            add_event(CMD_DATA, server_port_sel, BLK_W'(gen_block), full_length(), 1'b0);
         end else if (pick < 55) begin
            add_event(CMD_DATA, server_port_sel, BLK_W'(gen_block), full_length(), 1'b0);
         end else if (pick < 68) begin
            if (cfg_reply_timer)
               add_event(CMD_TIMEOUT, rnd_word(), rnd_word(), rnd_word(), rnd_bit());
            else
               add_event(CMD_OTHER, server_port_sel, rnd_word(), rnd_word(), rnd_bit());
         end else if (pick < 84) begin
            cmd = CMD_W'($urandom_range(CMD_DATA, CMD_SPARE_LAST));
            if (cmd == CMD_TIMEOUT) cmd = CMD_ERROR;
            add_event(cmd, foreign_port(), rnd_word(), rnd_word(), rnd_bit());
         end else if (pick < 94) begin
            add_event(CMD_W'($urandom_range(CMD_OTHER, CMD_SPARE_LAST)), server_port_sel,
                      rnd_word(), rnd_word(), rnd_bit());
         end else if (gen_block == 0) begin
            add_event(CMD_OACK, server_port_sel, rnd_word(), rnd_word(), rnd_bit());
         end else begin
            add_event(CMD_OACK, foreign_port(), rnd_word(), rnd_word(), rnd_bit());
         end
      end
   endtask

   // input side: acceptance and prediction
   always @(posedge clock) begin : predictor
      result_type predicted;
      req_taken = req_push && !req_full;
      if (!reset && req_taken) begin
         predicted = next_reply('{req_command, req_source_port,
            req_block_number, req_payload_length, req_write_failed});
         expected_replies = {expected_replies, predicted};
         accepted_count++;
      end
   end

   // driver
   always @(negedge clock) begin : driver
      packet_item_type ev;
      if (reset) begin
         req_push <= 1'b0;
      end else if (!req_push || req_taken) begin
         if (pending_events.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
            ev = pending_events.pop_front();
            req_push <= 1'b1;
            req_command <= ev.command;
            req_source_port <= ev.port;
            req_block_number <= ev.block;
            req_payload_length <= ev.length;
            req_write_failed <= ev.write_failed;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_pop <= 1'b0;
      else rsp_pop <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // monitor
   always @(posedge clock) begin : monitor
      result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_replies.size() == 0) begin
            report_mismatch("unexpected reply, send_kind", 32'(rsp_send_kind), 0);
         end else begin
            want = expected_replies.pop_front();
            if (rsp_send_kind !== want.send_kind)
               report_mismatch("send_kind", 32'(rsp_send_kind), 32'(want.send_kind));
            if (rsp_send_number !== want.send_number)
               report_mismatch("send_number", 32'(rsp_send_number),
                               32'(want.send_number));
            if (rsp_outcome !== want.outcome)
               report_mismatch("outcome", 32'(rsp_outcome), 32'(want.outcome));
            if (rsp_payload_accepted !== want.payload_accepted)
               report_mismatch("payload_accepted", 32'(rsp_payload_accepted),
                               32'(want.payload_accepted));
         end
         reply_index++;
      end
   end

   // long receiver stall while the sender keeps offering items
   initial begin
      @(posedge clock);
      while (accepted_count < 400) @(posedge clock);
      rx_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rx_hold = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tftp_read_receiver_core_tb failed");
         $finish;
      end
   end

   initial begin : stimulus
      int sizes[6];
      int timers[6];
      int end_kind;
      logic [BLK_W-1:0] bs;
      sizes = '{8, 65464, 512, 0, 0, 0};
      timers = '{1, 1, 0, 1, 0, 1};
      server_port_sel = PORT_W'($urandom_range(1, 65535));
      gen_block = 0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults: port latching, foreign ports, option ack before data
      add_event(CMD_OTHER, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1);
      add_event(CMD_SPARE_FIRST, server_port_sel, 16'h0000, 16'h0000, 1'b0);
      add_event(CMD_SPARE_LAST, foreign_port(), 16'hA5A5, 16'h5A5A, 1'b1);
      add_event(CMD_DATA, foreign_port(), 16'h0001, 16'h0000, 1'b1);
      add_event(CMD_OACK, server_port_sel, 16'h1234, 16'hFFFF, 1'b0);
      wait_idle();
      write_csr(REG_REPLY_TIMER, 16'h0001);

      // timer on: resend before data, repeats, option ack after block 0
      add_event(CMD_TIMEOUT, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      add_event(CMD_DATA, server_port_sel, 16'h0000, 16'd512, 1'b0);
      add_event(CMD_OACK, server_port_sel, 16'h0000, 16'h0000, 1'b0);
      add_event(CMD_DATA, server_port_sel, 16'h0001, 16'hFFFF, 1'b0);
      add_event(CMD_DATA, server_port_sel, 16'h0001, 16'd512, 1'b0);
      add_event(CMD_ERROR, foreign_port(), 16'h0000, 16'h0000, 1'b0);
      add_event(CMD_OACK, foreign_port(), 16'h0000, 16'h0000, 1'b0);
      add_event(CMD_SPARE_MID, server_port_sel, 16'hFFFF, 16'hFFFF, 1'b1);
      add_event(CMD_TIMEOUT, rnd_word(), 16'hFFFF, 16'hFFFF, 1'b1);
      add_event(CMD_DATA, foreign_port(), 16'hFFFF, 16'h0000, 1'b1);
      add_event(CMD_DATA, server_port_sel, 16'h0002, 16'd1000, 1'b0);
      gen_block = 2;
      wait_idle();

      for (int p = 0; p < 6; p++) begin
         case (p / 2)
            0: begin tx_idle_pct = 10; rx_idle_pct = 61; end
            1: begin tx_idle_pct = 61; rx_idle_pct = 10; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         bs = (sizes[p] == 0) ? BLK_W'($urandom_range(8, 65464)) : BLK_W'(sizes[p]);
         write_csr(REG_BLOCK_SIZE, bs);
         write_csr(REG_REPLY_TIMER, {15'($urandom_range(0, 32767)), timers[p][0]});
         queue_random_phase(320);
         wait_idle();
      end

      // one way of ending the transfer, then traffic after the end
      end_kind = $urandom_range(0, 5);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_csr(REG_REPLY_TIMER, {15'($urandom_range(0, 32767)),
                (end_kind == 5) ? 1'b0 : 1'($urandom_range(0, 1))});
      gen_block++;
      add_event(CMD_DATA, server_port_sel, BLK_W'(gen_block), full_length(), 1'b0);
      case (end_kind)
         0: begin
            add_event(CMD_DATA, server_port_sel, BLK_W'(gen_block + 1),
                      LEN_W'($urandom_range(0, int'(cfg_block_size) - 1)), 1'b0);
            gen_block++;
            add_event(CMD_DATA, server_port_sel, BLK_W'(gen_block), full_length(), 1'b0);
            add_event(CMD_OACK, foreign_port(), rnd_word(), rnd_word(), rnd_bit());
            add_event(CMD_OTHER, server_port_sel, rnd_word(), rnd_word(), rnd_bit());
            add_event(CMD_TIMEOUT, rnd_word(), rnd_word(), rnd_word(), rnd_bit());
         end
         1: add_event(CMD_DATA, server_port_sel,
                      BLK_W'(gen_block + $urandom_range(2, 60000)), rnd_word(), 1'b1);
         2: add_event(CMD_DATA, server_port_sel,
                      BLK_W'(gen_block + $urandom_range(2, 60000)), rnd_word(), 1'b0);
         3: add_event(CMD_OACK, server_port_sel, rnd_word(), rnd_word(), rnd_bit());
         4: add_event(CMD_ERROR, server_port_sel, rnd_word(), rnd_word(), rnd_bit());
         default: add_event(CMD_TIMEOUT, rnd_word(), rnd_word(), rnd_word(), rnd_bit());
      endcase
      for (int i = 0; i < 40; i++)
         add_event(CMD_W'($urandom_range(CMD_DATA, CMD_SPARE_LAST)),
                   ($urandom_range(0, 1) != 0) ? server_port_sel : foreign_port(),
                   rnd_word(), rnd_word(), rnd_bit());
      wait_idle();
      repeat (10) @(posedge clock);

      if (reply_errors == 0) begin
         $display("tftp_read_receiver_core_tb passed");
      end else begin
         $display("tftp_read_receiver_core_tb failed");
      end
      $finish;
   end

endmodule
